// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define PDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");

// The consequent holds a fixed number of cycles after the antecedent.
`define PDC_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("assertion failed: delayed consequence missing");

`else

`define PDC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PDC_ASSERT_DELAY(label, clk, rst, ante, n, cons)

`endif

`endif

// ===== src/pdc_pkg.sv =====
package pdc_pkg;

   // Channel format: unsigned fixed point, all ones stands for 1.0.
   localparam int CH_BITS   = 8;
   localparam int PROD_BITS = 2 * CH_BITS;
   localparam int MODE_BITS = 4;

   // Register stages from request to result: five arithmetic stages, one
   // division stage per quotient bit and the output register.
   localparam int LATENCY = CH_BITS + 6;

   typedef logic [CH_BITS-1:0]   chan_type;
   typedef logic [PROD_BITS-1:0] prod_type;

   localparam chan_type CH_MAX  = '1;
   localparam chan_type CH_HALF = CH_MAX >> 1;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_CLEAR    = 4'd0,
      MODE_SRC      = 4'd1,
      MODE_DST      = 4'd2,
      MODE_SRCOVER  = 4'd3,
      MODE_DSTOVER  = 4'd4,
      MODE_SRCIN    = 4'd5,
      MODE_DSTIN    = 4'd6,
      MODE_SRCOUT   = 4'd7,
      MODE_DSTOUT   = 4'd8,
      MODE_SRCATOP  = 4'd9,
      MODE_DSTATOP  = 4'd10,
      MODE_XOR      = 4'd11,
      MODE_PLUS     = 4'd12,
      MODE_MODULATE = 4'd13
   } blend_mode_type;

   localparam blend_mode_type MODE_RESET = MODE_SRCOVER;

   // Stage 1: raw products.
   typedef struct packed {
      prod_type [2:0] src_prod;
      prod_type [2:0] dst_prod;
      prod_type [2:0] mod_prod;
      prod_type       src_alpha_prod;
      prod_type       dst_alpha_prod;
      prod_type       mod_alpha_prod;
      chan_type       fa;
      chan_type       fb;
      logic           modulate;
   } s1_type;

   // Stage 2: products rescaled to channel range.
   typedef struct packed {
      chan_type [2:0] src_pm;
      chan_type [2:0] dst_pm;
      chan_type [2:0] mod_color;
      chan_type       alpha_a;
      chan_type       alpha_b;
      chan_type       mod_alpha;
      chan_type       fa;
      chan_type       fb;
      logic           modulate;
   } s2_type;

   // Stage 3: colour terms weighted by the blend factors, result alpha.
   typedef struct packed {
      prod_type [2:0] src_term;
      prod_type [2:0] dst_term;
      chan_type [2:0] mod_color;
      chan_type       alpha;
      logic           modulate;
   } s3_type;

   // Stage 4: premultiplied result colour.
   typedef struct packed {
      chan_type [2:0] color;
      chan_type [2:0] mod_color;
      chan_type       alpha;
      logic           modulate;
   } s4_type;

   // One lane of the restoring divider.
   typedef struct packed {
      prod_type rem;
      chan_type quo;
      logic     clamp;
   } div_lane_type;

   // What travels beside the divider lanes.
   typedef struct packed {
      chan_type       alpha;
      logic           modulate;
      chan_type [2:0] mod_color;
   } div_side_type;

   typedef struct packed {
      div_lane_type [2:0] lane;
      div_side_type       side;
   } div_stage_type;

   // Rounded product rescale: floor((p + CH_HALF) / CH_MAX), with the division
   // by all ones done as an add of the upper half and a shift.
   function automatic chan_type rescale(prod_type p);
      prod_type t;
      prod_type u;
      t = p + PROD_BITS'(CH_HALF);
      u = t + (t >> CH_BITS) + PROD_BITS'(1);
      return u[PROD_BITS-1:CH_BITS];
   endfunction

   // Sum of two channels, saturating at full scale.
   function automatic chan_type sat_add(chan_type a, chan_type b);
      logic [CH_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CH_BITS] ? CH_MAX : s[CH_BITS-1:0];
   endfunction

endpackage

// ===== src/porter_duff_pixel_compositor.sv =====
// Porter-Duff pixel compositor.
// A request carries one straight RGBA source pixel and one straight RGBA
// destination pixel on the req_ ports; it is taken at a rising edge with start
// high and busy low. busy is high only during reset, so one request may be
// issued in every cycle. Each request yields exactly one straight RGBA pixel
// on the rsp_ ports, shown for one cycle with rsp_strobe high, in request
// order. The receiver cannot hold results off and none are needed to.
// The pipeline has five arithmetic stages, one restoring divider stage per
// quotient bit, and the output register. Throughput is one pixel per cycle.
// The user must write the blend mode through csr_write_enable and
// csr_write_data only while no request is in flight; the block does not
// enforce this. Reset selects source-over. Modes 14 and 15 act as source.
// Reset clears all valid bits, so requests in flight are dropped.
`include "assert_macros.svh"

module porter_duff_pixel_compositor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  pdc_pkg::chan_type             req_src_red,
   input  pdc_pkg::chan_type             req_src_green,
   input  pdc_pkg::chan_type             req_src_blue,
   input  pdc_pkg::chan_type             req_src_alpha,
   input  pdc_pkg::chan_type             req_dst_red,
   input  pdc_pkg::chan_type             req_dst_green,
   input  pdc_pkg::chan_type             req_dst_blue,
   input  pdc_pkg::chan_type             req_dst_alpha,
   output logic                          rsp_strobe,
   output pdc_pkg::chan_type             rsp_out_red,
   output pdc_pkg::chan_type             rsp_out_green,
   output pdc_pkg::chan_type             rsp_out_blue,
   output pdc_pkg::chan_type             rsp_out_alpha,
   input  logic                          csr_write_enable,
   input  logic [pdc_pkg::MODE_BITS-1:0] csr_write_data
);
   import pdc_pkg::*;

   blend_mode_type csr_mode_ff;

   chan_type [2:0] src_color;
   chan_type [2:0] dst_color;
   chan_type       fa;
   chan_type       fb;
   logic           req_accept;

   logic   s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;

   div_stage_type div_in       [0:CH_BITS];
   div_stage_type div_ff       [0:CH_BITS];
   logic          div_valid_ff [0:CH_BITS];

   chan_type [2:0] rsp_color_in, rsp_color_ff;
   chan_type       rsp_alpha_in, rsp_alpha_ff;
   logic           rsp_strobe_ff;

   assign busy       = reset;
   assign req_accept = start && !busy;

   assign src_color = {req_src_blue, req_src_green, req_src_red};
   assign dst_color = {req_dst_blue, req_dst_green, req_dst_red};

   // Blend mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_mode_ff <= MODE_RESET;
      end else if (csr_write_enable) begin
         csr_mode_ff <= blend_mode_type'(csr_write_data);
      end
   end

   // Blend factors of the selected mode.
   always_comb begin
      unique case (csr_mode_ff)
         MODE_CLEAR:   begin fa = '0;                    fb = '0;                    end
         MODE_DST:     begin fa = '0;                    fb = CH_MAX;                end
         MODE_SRCOVER: begin fa = CH_MAX;                fb = CH_MAX - req_src_alpha; end
         MODE_DSTOVER: begin fa = CH_MAX - req_dst_alpha; fb = CH_MAX;                end
         MODE_SRCIN:   begin fa = req_dst_alpha;         fb = '0;                    end
         MODE_DSTIN:   begin fa = '0;                    fb = req_src_alpha;         end
         MODE_SRCOUT:  begin fa = CH_MAX - req_dst_alpha; fb = '0;                    end
         MODE_DSTOUT:  begin fa = '0;                    fb = CH_MAX - req_src_alpha; end
         MODE_SRCATOP: begin fa = req_dst_alpha;         fb = CH_MAX - req_src_alpha; end
         MODE_DSTATOP: begin fa = CH_MAX - req_dst_alpha; fb = req_src_alpha;         end
         MODE_XOR:     begin fa = CH_MAX - req_dst_alpha; fb = CH_MAX - req_src_alpha; end
         MODE_PLUS:    begin fa = CH_MAX;                fb = CH_MAX;                end
         default:      begin fa = CH_MAX;                fb = '0;                    end
      endcase
   end

   // Stage 1: premultiply, alpha weighting and modulate products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_in.src_prod[i] = PROD_BITS'(src_color[i]) * PROD_BITS'(req_src_alpha);
         s1_in.dst_prod[i] = PROD_BITS'(dst_color[i]) * PROD_BITS'(req_dst_alpha);
         s1_in.mod_prod[i] = PROD_BITS'(src_color[i]) * PROD_BITS'(dst_color[i]);
      end
      s1_in.src_alpha_prod = PROD_BITS'(req_src_alpha) * PROD_BITS'(fa);
      s1_in.dst_alpha_prod = PROD_BITS'(req_dst_alpha) * PROD_BITS'(fb);
      s1_in.mod_alpha_prod = PROD_BITS'(req_src_alpha) * PROD_BITS'(req_dst_alpha);
      s1_in.fa             = fa;
      s1_in.fb             = fb;
      s1_in.modulate       = (csr_mode_ff == MODE_MODULATE);
   end

   // Stage 2: rescale every product back to channel range.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_in.src_pm[i]    = rescale(s1_ff.src_prod[i]);
         s2_in.dst_pm[i]    = rescale(s1_ff.dst_prod[i]);
         s2_in.mod_color[i] = rescale(s1_ff.mod_prod[i]);
      end
      s2_in.alpha_a   = rescale(s1_ff.src_alpha_prod);
      s2_in.alpha_b   = rescale(s1_ff.dst_alpha_prod);
      s2_in.mod_alpha = rescale(s1_ff.mod_alpha_prod);
      s2_in.fa        = s1_ff.fa;
      s2_in.fb        = s1_ff.fb;
      s2_in.modulate  = s1_ff.modulate;
   end

   // Stage 3: weight premultiplied colours and form the result alpha.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_in.src_term[i] = PROD_BITS'(s2_ff.src_pm[i]) * PROD_BITS'(s2_ff.fa);
         s3_in.dst_term[i] = PROD_BITS'(s2_ff.dst_pm[i]) * PROD_BITS'(s2_ff.fb);
      end
      s3_in.mod_color = s2_ff.mod_color;
      s3_in.alpha     = s2_ff.modulate ? s2_ff.mod_alpha
                                       : sat_add(s2_ff.alpha_a, s2_ff.alpha_b);
      s3_in.modulate  = s2_ff.modulate;
   end

   // Stage 4: rescale the weighted terms and sum them with saturation.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_in.color[i] = sat_add(rescale(s3_ff.src_term[i]), rescale(s3_ff.dst_term[i]));
      end
      s4_in.mod_color = s3_ff.mod_color;
      s4_in.alpha     = s3_ff.alpha;
      s4_in.modulate  = s3_ff.modulate;
   end

   // Divider entry: numerator c * CH_MAX + alpha / 2. A colour at or above
   // alpha always gives a quotient of at least full scale, so it is flagged to clamp.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         div_in[0].lane[i].rem   = {s4_ff.color[i], {CH_BITS{1'b0}}}
                                   - PROD_BITS'(s4_ff.color[i])
                                   + PROD_BITS'(s4_ff.alpha >> 1);
         div_in[0].lane[i].quo   = '0;
         div_in[0].lane[i].clamp = (s4_ff.color[i] >= s4_ff.alpha);
      end
      div_in[0].side.alpha     = s4_ff.alpha;
      div_in[0].side.modulate  = s4_ff.modulate;
      div_in[0].side.mod_color = s4_ff.mod_color;
   end

   // Restoring divider: one quotient bit per stage, most significant first.
   for (genvar g = 1; g <= CH_BITS; g++) begin : g_div
      localparam int K = CH_BITS - g;

      always_comb begin
         prod_type shifted;
         shifted   = PROD_BITS'(div_ff[g-1].side.alpha) << K;
         div_in[g] = div_ff[g-1];
         for (int i = 0; i < 3; i++) begin
            if (div_ff[g-1].lane[i].rem >= shifted) begin
               div_in[g].lane[i].rem    = div_ff[g-1].lane[i].rem - shifted;
               div_in[g].lane[i].quo[K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[g] <= 1'b0;
         end else begin
            div_valid_ff[g] <= div_valid_ff[g-1];
         end
         div_ff[g] <= div_in[g];
      end
   end

   // Output select: transparent black, modulate colour, clamp or quotient.
   always_comb begin
      rsp_alpha_in = div_ff[CH_BITS].side.alpha;
      for (int i = 0; i < 3; i++) begin
         priority if (div_ff[CH_BITS].side.alpha == '0) begin
            rsp_color_in[i] = '0;
         end else if (div_ff[CH_BITS].side.modulate) begin
            rsp_color_in[i] = div_ff[CH_BITS].side.mod_color[i];
         end else if (div_ff[CH_BITS].lane[i].clamp) begin
            rsp_color_in[i] = CH_MAX;
         end else begin
            rsp_color_in[i] = div_ff[CH_BITS].lane[i].quo;
         end
      end
   end

   // Pipeline registers for the arithmetic stages and the output.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         s4_valid_ff     <= 1'b0;
         div_valid_ff[0] <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         s1_valid_ff     <= req_accept;
         s2_valid_ff     <= s1_valid_ff;
         s3_valid_ff     <= s2_valid_ff;
         s4_valid_ff     <= s3_valid_ff;
         div_valid_ff[0] <= s4_valid_ff;
         rsp_strobe_ff   <= div_valid_ff[CH_BITS];
      end
      s1_ff        <= s1_in;
      s2_ff        <= s2_in;
      s3_ff        <= s3_in;
      s4_ff        <= s4_in;
      div_ff[0]    <= div_in[0];
      rsp_color_ff <= rsp_color_in;
      rsp_alpha_ff <= rsp_alpha_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_red   = rsp_color_ff[0];
   assign rsp_out_green = rsp_color_ff[1];
   assign rsp_out_blue  = rsp_color_ff[2];
   assign rsp_out_alpha = rsp_alpha_ff;

   // Every request yields its result after the fixed latency, and no result
   // appears without a request that far back.
   `PDC_ASSERT_DELAY(a_req_gives_rsp, clock, reset, start && !busy, LATENCY, rsp_strobe)
   `PDC_ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_strobe, $past(start && !busy, LATENCY))
   // A result with zero coverage is transparent black.
   `PDC_ASSERT_IMPLY(a_zero_alpha_black, clock, reset, rsp_strobe && rsp_out_alpha == '0, rsp_out_red == '0 && rsp_out_green == '0 && rsp_out_blue == '0)

endmodule
